/* rtl/core/bpt_pkg.sv */
// Shared types, widths and arithmetic helpers for the Brownian particle tick core.
package bpt_pkg;

  // Store geometry and position format
  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int POS_W         = 24;
  localparam int FRAC_BITS     = 16;

  // Field widths fixed by the interface
  localparam int INDEX_W = 10;
  localparam int LOAD_W  = 24;
  localparam int NOISE_W = 16;
  localparam int DRAW_W  = 16;
  localparam int BOX_W   = 23;
  localparam int SCALE_W = 16;
  localparam int RAD_W   = 32;
  localparam int THR_W   = 17;
  localparam int CNT_W   = 11;
  localparam int FLASH_W = 11;
  localparam int SQACC_W = 43;
  localparam int TICK_W  = 32;

  // APB register file
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int REG_SEL_LO = 2;

  // Derived datapath widths
  localparam int PROD_W      = SCALE_W + 1 + NOISE_W;
  localparam int ROUND_SHIFT = 12;
  localparam int ROUND_HALF  = 2 ** (ROUND_SHIFT - 1);
  localparam int STEP_W      = PROD_W - ROUND_SHIFT;
  localparam int SUM_W       = POS_W + 1;
  localparam int WRAP_W      = POS_W + 2;
  localparam int SQ_W        = 2 * POS_W - 1;
  localparam int DSQ_W       = 2 * WRAP_W - 1;
  localparam int DISP_W      = DSQ_W + 1 - FRAC_BITS;

  // Reset values of the registers
  localparam logic [BOX_W-1:0]   BOX_RESET    = BOX_W'(1036188);
  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(7179);
  localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(65536);
  localparam logic [THR_W-1:0]   THRESH_RESET = THR_W'(52429);
  localparam logic [CNT_W-1:0]   COUNT_RESET  = CNT_W'(300);

  localparam logic [FLASH_W-1:0] FLASH_MAX = '1;
  localparam logic [SQACC_W-1:0] SQACC_MAX = '1;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    REG_BOX_LENGTH  = 3'd0,
    REG_STEP_SCALE  = 3'd1,
    REG_RADIUS_SQ   = 3'd2,
    REG_THRESHOLD   = 3'd3,
    REG_PART_COUNT  = 3'd4
  } reg_idx_t;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [WRAP_W-1:0] wrap_t;

  localparam wrap_t POS_HI = wrap_t'(2 ** (POS_W - 1) - 1);
  localparam wrap_t POS_LO = -POS_HI - wrap_t'(1);

  typedef struct packed {
    pos_t x;
    pos_t y;
  } xy_t;

  typedef struct packed {
    logic [BOX_W-1:0]   box_len;
    logic [SCALE_W-1:0] step_scale;
    logic [RAD_W-1:0]   radius_sq;
    logic [THR_W-1:0]   threshold;
    logic [INDEX_W-1:0] last_idx;
  } cfg_t;

  typedef struct packed {
    logic                      cmd;
    logic [INDEX_W-1:0]        idx;
    logic signed [LOAD_W-1:0]  load_x;
    logic signed [LOAD_W-1:0]  load_y;
    logic signed [NOISE_W-1:0] noise_x;
    logic signed [NOISE_W-1:0] noise_y;
    logic [DRAW_W-1:0]         draw;
  } item_t;

  // Particle state as it travels down the pipe
  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] idx;
    logic [DRAW_W-1:0]  draw;
    xy_t                pos;
    xy_t                start;
  } track_t;

  // Bypass view of one stage for the read-modify-write hazard
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    xy_t                pos;
    xy_t                start;
  } fwd_t;

  typedef struct packed {
    track_t             trk;
    logic               flash;
    logic [DSQ_W-1:0]   dxx;
    logic [DSQ_W-1:0]   dyy;
  } meas_t;

  typedef struct packed {
    xy_t                pos;
    logic               flashed;
    logic               done;
    logic [FLASH_W-1:0] ftot;
    logic [SQACC_W-1:0] dsum;
    logic [TICK_W-1:0]  tnum;
  } result_t;

  // Round the Q4.28 displacement to Q.16, floor after adding half
  function automatic step_t step_round(input prod_t p);
    logic signed [PROD_W:0] t;
    t = (PROD_W + 1)'(p) + (PROD_W + 1)'(ROUND_HALF);
    return step_t'(t >>> ROUND_SHIFT);
  endfunction

  // One periodic correction; ties stay
  function automatic wrap_t wrap_once(input sum_t v, input logic [BOX_W-1:0] len);
    wrap_t v2;
    wrap_t l;
    v2 = wrap_t'(v) <<< 1;
    l  = wrap_t'({1'b0, len});
    if (v2 > l) begin
      return wrap_t'(v) - l;
    end else if (v2 < -l) begin
      return wrap_t'(v) + l;
    end
    return wrap_t'(v);
  endfunction

  function automatic pos_t sat_pos(input wrap_t v);
    if (v > POS_HI) begin
      return pos_t'(POS_HI);
    end else if (v < POS_LO) begin
      return pos_t'(POS_LO);
    end
    return pos_t'(v);
  endfunction

endpackage

/* rtl/core/bpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bpt_step.sv */
// Displacement multiply, store bypass, position update and periodic wrap.
module bpt_step import bpt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  cfg_t   cfg,
  input  logic   s1_valid,
  input  item_t  s1_item,
  input  xy_t    rd_pos,
  input  xy_t    rd_start,
  input  fwd_t   fwd4,
  input  fwd_t   fwd5,
  output logic   s3_valid,
  output track_t s3
);

  logic               s2_valid;
  logic               s2_cmd;
  logic [INDEX_W-1:0] s2_idx;
  xy_t                s2_load;
  logic [DRAW_W-1:0]  s2_draw;
  prod_t              s2_px;
  prod_t              s2_py;
  xy_t                s2_rd_pos;
  xy_t                s2_rd_start;

  prod_t px;
  prod_t py;
  fwd_t  fwd3;
  xy_t   base_pos;
  xy_t   base_start;
  sum_t  sum_x;
  sum_t  sum_y;
  xy_t   new_pos;
  xy_t   new_start;

  // Scale the noise samples
  always_comb begin
    px = $signed({1'b0, cfg.step_scale}) * $signed(s1_item.noise_x);
    py = $signed({1'b0, cfg.step_scale}) * $signed(s1_item.noise_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cmd      <= s1_item.cmd;
      s2_idx      <= s1_item.idx;
      s2_load.x   <= sat_pos(wrap_t'($signed(s1_item.load_x)));
      s2_load.y   <= sat_pos(wrap_t'($signed(s1_item.load_y)));
      s2_draw     <= s1_item.draw;
      s2_px       <= px;
      s2_py       <= py;
      s2_rd_pos   <= rd_pos;
      s2_rd_start <= rd_start;
    end
  end

  assign fwd3 = '{valid: s3_valid, idx: s3.idx, pos: s3.pos, start: s3.start};

  // Take the newest in-flight copy of this particle, else the store
  always_comb begin
    base_pos   = s2_rd_pos;
    base_start = s2_rd_start;
    priority if (fwd3.valid && fwd3.idx[IDX_W-1:0] == s2_idx[IDX_W-1:0]) begin
      base_pos   = fwd3.pos;
      base_start = fwd3.start;
    end else if (fwd4.valid && fwd4.idx[IDX_W-1:0] == s2_idx[IDX_W-1:0]) begin
      base_pos   = fwd4.pos;
      base_start = fwd4.start;
    end else if (fwd5.valid && fwd5.idx[IDX_W-1:0] == s2_idx[IDX_W-1:0]) begin
      base_pos   = fwd5.pos;
      base_start = fwd5.start;
    end else begin
      base_pos   = s2_rd_pos;
      base_start = s2_rd_start;
    end
  end

  // Advance, wrap once and saturate; a load replaces both positions
  always_comb begin
    sum_x = SUM_W'($signed(base_pos.x)) + SUM_W'(step_round(s2_px));
    sum_y = SUM_W'($signed(base_pos.y)) + SUM_W'(step_round(s2_py));
    if (s2_cmd == CMD_LOAD) begin
      new_pos   = s2_load;
      new_start = s2_load;
    end else begin
      new_pos.x = sat_pos(wrap_once(sum_x, cfg.box_len));
      new_pos.y = sat_pos(wrap_once(sum_y, cfg.box_len));
      new_start = base_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3.cmd   <= s2_cmd;
      s3.idx   <= s2_idx;
      s3.draw  <= s2_draw;
      s3.pos   <= new_pos;
      s3.start <= new_start;
    end
  end

endmodule

/* rtl/core/bpt_measure.sv */
// Squared radius, flash decision and squared displacement from the start.
module bpt_measure import bpt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  cfg_t   cfg,
  input  logic   s3_valid,
  input  track_t s3,
  output fwd_t   fwd4,
  output fwd_t   fwd5,
  output logic   s5_valid,
  output meas_t  s5
);

  logic              s4_valid;
  track_t            s4_trk;
  logic [SQ_W-1:0]   s4_xx;
  logic [SQ_W-1:0]   s4_yy;
  wrap_t             s4_dx;
  wrap_t             s4_dy;

  logic signed [2*POS_W-1:0]  xx_full;
  logic signed [2*POS_W-1:0]  yy_full;
  wrap_t                      dx;
  wrap_t                      dy;
  logic [SQ_W:0]              rsum;
  logic                       flash;
  logic signed [2*WRAP_W-1:0] dxx_full;
  logic signed [2*WRAP_W-1:0] dyy_full;

  // Square the position and form the wrapped displacement
  always_comb begin
    xx_full = $signed(s3.pos.x) * $signed(s3.pos.x);
    yy_full = $signed(s3.pos.y) * $signed(s3.pos.y);
    dx = wrap_once(SUM_W'($signed(s3.pos.x)) - SUM_W'($signed(s3.start.x)), cfg.box_len);
    dy = wrap_once(SUM_W'($signed(s3.pos.y)) - SUM_W'($signed(s3.start.y)), cfg.box_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_trk <= s3;
      s4_xx  <= xx_full[SQ_W-1:0];
      s4_yy  <= yy_full[SQ_W-1:0];
      s4_dx  <= dx;
      s4_dy  <= dy;
    end
  end

  // Flash a step when inside the sampling circle and the draw is below threshold
  always_comb begin
    rsum  = (SQ_W + 1)'(s4_xx) + (SQ_W + 1)'(s4_yy);
    flash = (s4_trk.cmd == CMD_STEP)
         && ((rsum >> FRAC_BITS) <= (SQ_W + 1)'(cfg.radius_sq))
         && (THR_W'(s4_trk.draw) < cfg.threshold);
    dxx_full = $signed(s4_dx) * $signed(s4_dx);
    dyy_full = $signed(s4_dy) * $signed(s4_dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (advance) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5.trk   <= s4_trk;
      s5.flash <= flash;
      s5.dxx   <= dxx_full[DSQ_W-1:0];
      s5.dyy   <= dyy_full[DSQ_W-1:0];
    end
  end

  assign fwd4 = '{valid: s4_valid, idx: s4_trk.idx, pos: s4_trk.pos, start: s4_trk.start};
  assign fwd5 = '{valid: s5_valid, idx: s5.trk.idx, pos: s5.trk.pos, start: s5.trk.start};

endmodule

/* rtl/core/bpt_accum.sv */
// Tick accumulators, tick close and the output register.
module bpt_accum import bpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  cfg_t    cfg,
  input  logic    s5_valid,
  input  meas_t   s5,
  output logic    out_valid,
  output result_t res
);

  logic [FLASH_W-1:0] flash_acc;
  logic [SQACC_W-1:0] sq_acc;
  logic [TICK_W-1:0]  tick_count;

  logic [DSQ_W:0]     dsq_sum;
  logic [DISP_W-1:0]  disp;
  logic [SQACC_W:0]   acc_sum;
  logic               is_step;
  logic               close;
  logic [FLASH_W-1:0] flash_acc_next;
  logic [SQACC_W-1:0] sq_acc_next;
  result_t            res_next;

  // Saturating sums including this particle
  always_comb begin
    dsq_sum = (DSQ_W + 1)'(s5.dxx) + (DSQ_W + 1)'(s5.dyy);
    disp    = DISP_W'(dsq_sum >> FRAC_BITS);
    acc_sum = (SQACC_W + 1)'(sq_acc) + (SQACC_W + 1)'(disp);
    is_step = (s5.trk.cmd == CMD_STEP);
    close   = is_step && (s5.trk.idx == cfg.last_idx);

    flash_acc_next = flash_acc;
    if (s5.flash && flash_acc < FLASH_MAX) begin
      flash_acc_next = flash_acc + 1'b1;
    end
    sq_acc_next = acc_sum[SQACC_W] ? SQACC_MAX : acc_sum[SQACC_W-1:0];

    res_next         = '0;
    res_next.pos     = s5.trk.pos;
    res_next.flashed = s5.flash;
    if (close) begin
      res_next.done = 1'b1;
      res_next.ftot = flash_acc_next;
      res_next.dsum = sq_acc_next;
      res_next.tnum = tick_count;
    end
  end

  // Update totals on steps; clear them when a tick closes
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_acc  <= '0;
      sq_acc     <= '0;
      tick_count <= '0;
    end else if (advance && s5_valid && is_step) begin
      if (close) begin
        flash_acc  <= '0;
        sq_acc     <= '0;
        tick_count <= tick_count + 1'b1;
      end else begin
        flash_acc <= flash_acc_next;
        sq_acc    <= sq_acc_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/core/brownian_particle_tick_update_core.sv */
// Brownian particle tick core: one particle item in, one result beat out.
// An accepted beat passes stages s1 to s5 and then the output register.
// Throughput: one beat per cycle; the whole pipe holds only while a result waits.
// Positions live in two 1024-entry RAMs, read on accept and written from stage s3.
// Reset (synchronous) clears valid bits, accumulators and tick counter and
// restores register defaults; store contents are undefined until loaded.
module brownian_particle_tick_update_core import bpt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [INDEX_W-1:0]         particle_index,
  input  logic signed [LOAD_W-1:0]   load_x,
  input  logic signed [LOAD_W-1:0]   load_y,
  input  logic signed [NOISE_W-1:0]  noise_x,
  input  logic signed [NOISE_W-1:0]  noise_y,
  input  logic [DRAW_W-1:0]          uniform_draw,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [LOAD_W-1:0]   pos_x,
  output logic signed [LOAD_W-1:0]   pos_y,
  output logic                       flashed,
  output logic                       tick_done,
  output logic [FLASH_W-1:0]         flash_total,
  output logic [SQACC_W-1:0]         displacement_sum,
  output logic [TICK_W-1:0]          tick_number,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [BOX_W-1:0]   box_length;
  logic [SCALE_W-1:0] step_scale;
  logic [RAD_W-1:0]   sample_radius_sq;
  logic [THR_W-1:0]   flash_threshold;
  logic [CNT_W-1:0]   particle_count;
  logic [INDEX_W-1:0] last_idx;
  cfg_t               cfg;

  logic    advance;
  logic    s1_valid;
  item_t   s1_item;
  xy_t     rd_pos;
  xy_t     rd_start;
  fwd_t    fwd4;
  fwd_t    fwd5;
  logic    s3_valid;
  track_t  s3;
  logic    s5_valid;
  meas_t   s5;
  result_t res;

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_length       <= BOX_RESET;
      step_scale       <= SCALE_RESET;
      sample_radius_sq <= RADIUS_RESET;
      flash_threshold  <= THRESH_RESET;
      particle_count   <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[ADDR_W-1:REG_SEL_LO])
        REG_BOX_LENGTH: box_length       <= pwdata[BOX_W-1:0];
        REG_STEP_SCALE: step_scale       <= pwdata[SCALE_W-1:0];
        REG_RADIUS_SQ:  sample_radius_sq <= pwdata[RAD_W-1:0];
        REG_THRESHOLD:  flash_threshold  <= pwdata[THR_W-1:0];
        REG_PART_COUNT: particle_count   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register file reads
  always_comb begin
    unique case (paddr[ADDR_W-1:REG_SEL_LO])
      REG_BOX_LENGTH: prdata = DATA_W'(box_length);
      REG_STEP_SCALE: prdata = DATA_W'(step_scale);
      REG_RADIUS_SQ:  prdata = DATA_W'(sample_radius_sq);
      REG_THRESHOLD:  prdata = DATA_W'(flash_threshold);
      REG_PART_COUNT: prdata = DATA_W'(particle_count);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Clamp the particle count and find the index that closes a tick
  always_comb begin
    if (particle_count == '0) begin
      last_idx = '0;
    end else if (particle_count > CNT_W'(MAX_PARTICLES)) begin
      last_idx = INDEX_W'(MAX_PARTICLES - 1);
    end else begin
      last_idx = INDEX_W'(particle_count - 1'b1);
    end
    cfg = '{box_len: box_length, step_scale: step_scale, radius_sq: sample_radius_sq,
            threshold: flash_threshold, last_idx: last_idx};
  end

  // Whole pipe moves unless the output register holds an untaken beat
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= '{cmd: command, idx: particle_index, load_x: load_x, load_y: load_y,
                   noise_x: noise_x, noise_y: noise_y, draw: uniform_draw};
    end
  end

  bpt_ram #(.WIDTH($bits(xy_t)), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (advance && s3_valid),
    .waddr (s3.idx[IDX_W-1:0]),
    .wdata (s3.pos),
    .re    (advance),
    .raddr (particle_index[IDX_W-1:0]),
    .rdata (rd_pos)
  );

  bpt_ram #(.WIDTH($bits(xy_t)), .DEPTH(MAX_PARTICLES)) u_start_ram (
    .clk   (clk),
    .we    (advance && s3_valid && s3.cmd == CMD_LOAD),
    .waddr (s3.idx[IDX_W-1:0]),
    .wdata (s3.start),
    .re    (advance),
    .raddr (particle_index[IDX_W-1:0]),
    .rdata (rd_start)
  );

  bpt_step u_step (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rd_pos   (rd_pos),
    .rd_start (rd_start),
    .fwd4     (fwd4),
    .fwd5     (fwd5),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  bpt_measure u_measure (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cfg      (cfg),
    .s3_valid (s3_valid),
    .s3       (s3),
    .fwd4     (fwd4),
    .fwd5     (fwd5),
    .s5_valid (s5_valid),
    .s5       (s5)
  );

  bpt_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cfg       (cfg),
    .s5_valid  (s5_valid),
    .s5        (s5),
    .out_valid (out_valid),
    .res       (res)
  );

  assign pos_x            = LOAD_W'(res.pos.x);
  assign pos_y            = LOAD_W'(res.pos.y);
  assign flashed          = res.flashed;
  assign tick_done        = res.done;
  assign flash_total      = res.ftot;
  assign displacement_sum = res.dsum;
  assign tick_number      = res.tnum;

  // Hold the front stage while the pipe is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !in_ready |=> s1_valid && $stable(s1_item))
    else $error("front stage lost or changed its beat during a stall");

  // Totals are zero except on the beat that closes a tick
  a_totals_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tick_done |-> flash_total == '0 && displacement_sum == '0
                                && tick_number == '0)
    else $error("tick totals present on a beat that does not close a tick");

  // A closing particle that flashed is counted in its own tick
  a_flash_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && tick_done && flashed |-> flash_total != '0)
    else $error("closing flash missing from the tick total");

endmodule
